### rtl/core/scp_pkg.sv
// scp_pkg: shared types, character codes and parser states of the setpoint
// command parser. No dependencies.
package scp_pkg;

  // character codes
  localparam logic [7:0] CH_NONE  = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [3:0] DIGIT_HI = 4'h3;

  // setpoint reset values (tens)
  localparam logic [3:0] SP1_RST = 4'd5;
  localparam logic [3:0] SP2_RST = 4'd3;
  localparam logic [3:0] SP3_RST = 4'd1;

  // reply queue
  localparam int QDEPTH = 2;
  localparam int QPTRW  = $clog2(QDEPTH);
  localparam int QCNTW  = $clog2(QDEPTH + 1);

  // last character position of a reply frame
  localparam logic [2:0] REPLY_LAST = 3'd5;

  // parser states; code 0 is unused and behaves as hunting
  typedef enum logic [2:0] {
    ST_HUNT = 3'd1,
    ST_CMD  = 3'd2,
    ST_QA   = 3'd3,
    ST_QB   = 3'd4,
    ST_X    = 3'd5,
    ST_Y    = 3'd6,
    ST_Z    = 3'd7
  } parse_state_t;

  // one pending reply: three value digits and the check digit
  typedef struct packed {
    logic [3:0] d0;
    logic [3:0] d1;
    logic [3:0] d2;
    logic [3:0] chk;
  } reply_t;

  // queue status towards front, back and top
  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCNTW-1:0] count;
  } q_stat_t;

endpackage

### rtl/core/scp_front.sv
// scp_front: frame parser. Takes characters, tracks the frame, holds the
// setpoints and pushes reply descriptors. Depends on scp_pkg.
module scp_front import scp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_char,
  input  logic       valve_one,
  input  logic       valve_two,
  input  logic       valve_three,
  input  q_stat_t    q_stat,
  output logic       push,
  output reply_t     push_data
);

  parse_state_t state_r, state_nxt;
  logic [3:0] first_r, first_nxt;
  logic [3:0] second_r, second_nxt;
  logic       third_r, third_nxt;
  logic [3:0] sp1_r, sp1_nxt;
  logic [3:0] sp2_r, sp2_nxt;
  logic [3:0] sp3_r, sp3_nxt;

  logic       fire;
  logic       is_digit, is_nz_digit, is_bit;
  logic [4:0] sum_xy;
  logic [1:0] vsum;

  // a character is taken whenever a reply slot is free
  assign in_ready = !q_stat.full;
  assign fire     = in_valid && in_ready && (rx_char != CH_NONE);

  assign is_digit    = (rx_char >= CH_0) && (rx_char <= CH_9);
  assign is_nz_digit = (rx_char >= CH_1) && (rx_char <= CH_9);
  assign is_bit      = (rx_char == CH_0) || (rx_char == CH_1);
  assign sum_xy      = {1'b0, first_r} + {1'b0, second_r};
  assign vsum        = {1'b0, valve_one} + {1'b0, valve_two} + {1'b0, valve_three};

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_HUNT;
      first_r  <= '0;
      second_r <= '0;
      third_r  <= 1'b0;
      sp1_r    <= SP1_RST;
      sp2_r    <= SP2_RST;
      sp3_r    <= SP3_RST;
    end else begin
      state_r  <= state_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      third_r  <= third_nxt;
      sp1_r    <= sp1_nxt;
      sp2_r    <= sp2_nxt;
      sp3_r    <= sp3_nxt;
    end
  end

  // frame parsing, setpoint updates and reply requests
  always_comb begin
    state_nxt  = state_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    third_nxt  = third_r;
    sp1_nxt    = sp1_r;
    sp2_nxt    = sp2_r;
    sp3_nxt    = sp3_r;
    push       = 1'b0;
    push_data  = '0;
    if (fire) begin
      state_nxt = ST_HUNT;
      case (state_r)
        ST_CMD: begin
          if (rx_char == CH_A) begin
            state_nxt = ST_QA;
          end else if (rx_char == CH_B) begin
            state_nxt = ST_QB;
          end else if (is_nz_digit) begin
            first_nxt = rx_char[3:0];
            state_nxt = ST_X;
          end
        end
        ST_QA: begin
          if (rx_char == CH_HASH) begin
            push          = 1'b1;
            push_data.d0  = sp1_r;
            push_data.d1  = sp2_r;
            push_data.d2  = sp3_r;
            push_data.chk = {3'b000, sp1_r[0] ^ sp2_r[0] ^ sp3_r[0]};
          end
        end
        ST_QB: begin
          if (rx_char == CH_HASH) begin
            push          = 1'b1;
            push_data.d0  = {3'b000, valve_one};
            push_data.d1  = {3'b000, valve_two};
            push_data.d2  = {3'b000, valve_three};
            // (4 - s) mod 4
            push_data.chk = {2'b00, 2'd0 - vsum};
          end
        end
        ST_X: begin
          if (is_digit) begin
            second_nxt = rx_char[3:0];
            state_nxt  = ST_Y;
          end
        end
        ST_Y: begin
          if (rx_char == CH_HASH) begin
            if ((first_r >= 4'd1) && (first_r <= 4'd9) && (second_r <= 4'd4) &&
                ((sum_xy == 5'd5) || (sum_xy == 5'd10))) begin
              sp1_nxt = first_r;
            end
          end else if (is_bit) begin
            third_nxt = rx_char[0];
            state_nxt = ST_Z;
          end
        end
        ST_Z: begin
          if (rx_char == CH_HASH) begin
            if ((first_r >= 4'd1) && (first_r <= 4'd9) && (second_r >= 4'd1) &&
                (second_r <= 4'd9) && !(first_r[0] ^ second_r[0] ^ third_r)) begin
              sp2_nxt = first_r;
              sp3_nxt = second_r;
            end
          end
        end
        default: begin
          // hunting, also for the unused code
          if (rx_char == CH_COLON) state_nxt = ST_CMD;
        end
      endcase
    end
  end

endmodule

### rtl/core/scp_queue.sv
// scp_queue: two-entry reply descriptor queue between parser and serialiser.
// Depends on scp_pkg.
module scp_queue import scp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  reply_t  push_data,
  input  logic    pop,
  output reply_t  head,
  output q_stat_t stat
);

  reply_t           mem [QDEPTH];
  logic [QPTRW-1:0] wr_r, wr_nxt;
  logic [QPTRW-1:0] rd_r, rd_nxt;
  logic [QCNTW-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == QCNTW'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.count = cnt_r;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_r];

  // pointer and fill count update
  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= push_data;
  end

endmodule

### rtl/core/scp_back.sv
// scp_back: reply serialiser. Sends the six characters of the queue head
// one transfer at a time. Depends on scp_pkg.
module scp_back import scp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  reply_t     head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_char,
  output logic       out_tx_last
);

  logic [2:0] idx_r, idx_nxt;
  logic       fire;

  assign out_valid   = !q_stat.empty;
  assign fire        = out_valid && out_ready;
  assign out_tx_last = (idx_r == REPLY_LAST);
  assign pop         = fire && out_tx_last;

  // character position within the reply
  always_comb begin
    idx_nxt = idx_r;
    if (fire) idx_nxt = out_tx_last ? 3'd0 : idx_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // character select; digits go out as '0' plus the low nibble
  always_comb begin
    case (idx_r)
      3'd0:    out_tx_char = CH_COLON;
      3'd1:    out_tx_char = {DIGIT_HI, head.d0};
      3'd2:    out_tx_char = {DIGIT_HI, head.d1};
      3'd3:    out_tx_char = {DIGIT_HI, head.d2};
      3'd4:    out_tx_char = {DIGIT_HI, head.chk};
      default: out_tx_char = CH_HASH;
    endcase
  end

endmodule

### rtl/core/setpoint_command_parser.sv
// setpoint_command_parser: top level, joins parser, reply queue and
// serialiser. Depends on scp_pkg, scp_front, scp_queue, scp_back.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one received character
//   per transfer with the three valve states; a zero character is taken
//   and ignored. The result channel (out_valid/out_ready) carries reply
//   characters, out_tx_last marking the closing '#'.
//   One character is taken per cycle while the reply queue has room. A
//   query's six-character reply is written into the queue when its '#'
//   is taken and, once at the queue head, goes out at one character per
//   cycle while the receiver is ready. The two-entry reply queue holds
//   pending replies: while the receiver stalls, characters are still
//   taken until two replies are waiting, then in_ready drops until a
//   reply has fully gone.
//   Reset clears the parser to hunting for ':', restores setpoints 5, 3
//   and 1 tens and empties the queue.
module setpoint_command_parser import scp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_char,
  input  logic       in_valve_one,
  input  logic       in_valve_two,
  input  logic       in_valve_three,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_char,
  output logic       out_tx_last
);

  q_stat_t q_stat;
  reply_t  push_data;
  reply_t  head;
  logic    push;
  logic    pop;

  scp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_char     (in_rx_char),
    .valve_one   (in_valve_one),
    .valve_two   (in_valve_two),
    .valve_three (in_valve_three),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data)
  );

  scp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  scp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_tx_char (out_tx_char),
    .out_tx_last (out_tx_last)
  );

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNTW'(QDEPTH))
    else $error("reply queue count beyond depth");

  // a reply is never dropped: no push while full
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("reply pushed into a full queue");

  // the closing character of a reply is always '#'
  a_last_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tx_last) |-> (out_tx_char == CH_HASH))
    else $error("reply end not marked on '#'");

  // after the last transfer of a reply the next one opens with ':'
  a_open_colon: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_tx_last) |=> (!out_valid || out_tx_char == CH_COLON))
    else $error("reply does not open with ':'");

endmodule
